### src/stsc_pkg.sv
// ----------------------------------------------------------------------------
// stsc_pkg
// shared widths, register indexes, reset values and interface types of the
// super-twisting steering controller
// ----------------------------------------------------------------------------
package stsc_pkg;

    localparam int PIXEL_W   = 12;
    localparam int ANGLE_W   = 24;
    localparam int SIGN_W    = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam int SCALE_W   = 24;
    localparam int GAIN_W    = 20;
    localparam int PERIOD_W  = 16;

    localparam int STATE_W   = 32;
    localparam int MAG_W     = 50;
    localparam int ROOT_W    = MAG_W / 2;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_SCALE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SURFACE_GAIN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERSE_PERIOD  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEGRATOR_STEP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROOT_GAIN       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DEGREE_SCALE    = 3'd5;

    localparam logic [SCALE_W-1:0]  RST_PIXEL_SCALE     = 24'd3670;
    localparam logic [GAIN_W-1:0]   RST_SURFACE_GAIN    = 20'd52429;
    localparam logic [PERIOD_W-1:0] RST_INVERSE_PERIOD  = 16'd100;
    localparam logic [GAIN_W-1:0]   RST_INTEGRATOR_STEP = 20'd2097;
    localparam logic [GAIN_W-1:0]   RST_ROOT_GAIN       = 20'd22938;
    localparam logic [SCALE_W-1:0]  RST_DEGREE_SCALE    = 24'd3754924;

    localparam logic [SIGN_W-1:0] SGN_ZERO = 2'b00;
    localparam logic [SIGN_W-1:0] SGN_POS  = 2'b01;
    localparam logic [SIGN_W-1:0] SGN_NEG  = 2'b11;

    typedef struct packed {
        logic [SCALE_W-1:0]  pixel_scale;
        logic [GAIN_W-1:0]   surface_gain;
        logic [PERIOD_W-1:0] inverse_period;
        logic [GAIN_W-1:0]   integrator_step;
        logic [GAIN_W-1:0]   root_gain;
        logic [SCALE_W-1:0]  degree_scale;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic scale;
        logic c1_mul;
        logic diff_mul;
        logic sigma;
        logic integ;
        logic root_step;
        logic gain_mul;
        logic u_form;
        logic deg_hi;
        logic deg_lo;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

### src/stsc_cfg.sv
// ----------------------------------------------------------------------------
// stsc_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module stsc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stsc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [stsc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output stsc_pkg::t_cfg                      o_cfg
);
    import stsc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_scale     <= RST_PIXEL_SCALE;
            r_cfg.surface_gain    <= RST_SURFACE_GAIN;
            r_cfg.inverse_period  <= RST_INVERSE_PERIOD;
            r_cfg.integrator_step <= RST_INTEGRATOR_STEP;
            r_cfg.root_gain       <= RST_ROOT_GAIN;
            r_cfg.degree_scale    <= RST_DEGREE_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PIXEL_SCALE:     r_cfg.pixel_scale     <= i_cfg_wdata[SCALE_W-1:0];
                REG_SURFACE_GAIN:    r_cfg.surface_gain    <= i_cfg_wdata[GAIN_W-1:0];
                REG_INVERSE_PERIOD:  r_cfg.inverse_period  <= i_cfg_wdata[PERIOD_W-1:0];
                REG_INTEGRATOR_STEP: r_cfg.integrator_step <= i_cfg_wdata[GAIN_W-1:0];
                REG_ROOT_GAIN:       r_cfg.root_gain       <= i_cfg_wdata[GAIN_W-1:0];
                REG_DEGREE_SCALE:    r_cfg.degree_scale    <= i_cfg_wdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/stsc_ctrl.sv
// ----------------------------------------------------------------------------
// stsc_ctrl
// sequencer: steps the datapath through scaling, surface, integrator,
// square root and degree conversion for one item
// ----------------------------------------------------------------------------
module stsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  stsc_pkg::t_sts  i_sts,
    output stsc_pkg::t_cmd  o_cmd
);
    import stsc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCALE = 4'd1;
    localparam logic [3:0] ST_C1    = 4'd2;
    localparam logic [3:0] ST_DIFF  = 4'd3;
    localparam logic [3:0] ST_SIG   = 4'd4;
    localparam logic [3:0] ST_INT   = 4'd5;
    localparam logic [3:0] ST_ROOT  = 4'd6;
    localparam logic [3:0] ST_RG    = 4'd7;
    localparam logic [3:0] ST_U     = 4'd8;
    localparam logic [3:0] ST_DHI   = 4'd9;
    localparam logic [3:0] ST_DLO   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    localparam logic [ROOT_CNT_W-1:0] ROOT_LAST = ROOT_CNT_W'(ROOT_STEPS - 1);

    logic [3:0]            r_state, n_state;
    logic [ROOT_CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_C1;
            end
            ST_C1: begin
                o_cmd.c1_mul = 1'b1;
                n_state      = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff_mul = 1'b1;
                n_state        = ST_SIG;
            end
            ST_SIG: begin
                o_cmd.sigma = 1'b1;
                n_state     = ST_INT;
            end
            ST_INT: begin
                o_cmd.integ = 1'b1;
                n_cnt       = '0;
                n_state     = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == ROOT_LAST) begin
                    n_state = ST_RG;
                end
            end
            ST_RG: begin
                o_cmd.gain_mul = 1'b1;
                n_state        = ST_U;
            end
            ST_U: begin
                o_cmd.u_form = 1'b1;
                n_state      = ST_DHI;
            end
            ST_DHI: begin
                o_cmd.deg_hi = 1'b1;
                n_state      = ST_DLO;
            end
            ST_DLO: begin
                o_cmd.deg_lo = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

### src/stsc_dp.sv
// ----------------------------------------------------------------------------
// stsc_dp
// datapath: shared multiply steps, sliding surface, saturating integrator,
// bit-serial square root and the output register
// ----------------------------------------------------------------------------
module stsc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stsc_pkg::t_cmd                      i_cmd,
    output stsc_pkg::t_sts                      o_sts,
    input  stsc_pkg::t_cfg                      i_cfg,
    input  logic signed [stsc_pkg::PIXEL_W-1:0] i_pixel_error,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [stsc_pkg::ANGLE_W-1:0]        o_angle,
    output logic [stsc_pkg::SIGN_W-1:0]         o_surface_sign,
    output logic                                o_saturated
);
    import stsc_pkg::*;

    // input and error
    logic signed [PIXEL_W-1:0] r_px;
    logic signed [STATE_W-1:0] r_e;
    logic signed [STATE_W-1:0] r_prev;
    logic signed [STATE_W-1:0] r_int;
    logic                      r_sat_i;

    // surface
    logic signed [36:0] r_c1s;
    logic signed [49:0] r_dp;
    logic [SIGN_W-1:0]  r_sgn;
    logic [MAG_W-1:0]   r_mag;

    // root
    logic [MAG_W-1:0]   r_rad;
    logic [ROOT_W:0]    r_rem;
    logic [ROOT_W-1:0]  r_root;

    // output path
    logic [38:0]        r_rt;
    logic               r_uneg;
    logic [40:0]        r_um;
    logic [40:0]        r_dhi;
    logic [23:0]        r_dlo;

    logic               r_ovalid;
    logic [ANGLE_W-1:0] r_angle;
    logic [SIGN_W-1:0]  r_osgn;
    logic               r_osat;

    logic signed [36:0] w_pxp;
    logic signed [37:0] w_neg;
    logic signed [52:0] w_c1p;
    logic signed [32:0] w_diff;
    logic signed [49:0] w_dpm;
    logic signed [50:0] w_sigma;
    logic signed [50:0] w_sigma_abs;
    logic signed [33:0] w_step;
    logic signed [33:0] w_isum;
    logic [ROOT_W+2:0]  w_rem_t;
    logic [ROOT_W+2:0]  w_trial;
    logic [ROOT_W+2:0]  w_rem_d;
    logic [44:0]        w_rgp;
    logic signed [40:0] w_rts;
    logic signed [40:0] w_u;
    logic [47:0]        w_dlo;
    logic [41:0]        w_om;
    logic [ANGLE_W-1:0] w_angle;
    logic               w_clip;

    assign w_pxp  = r_px * $signed({1'b0, i_cfg.pixel_scale});
    assign w_neg  = -{w_pxp[36], w_pxp};
    assign w_c1p  = $signed({1'b0, i_cfg.surface_gain}) * r_e;
    assign w_diff = {r_e[STATE_W-1], r_e} - {r_prev[STATE_W-1], r_prev};
    assign w_dpm  = w_diff * $signed({1'b0, i_cfg.inverse_period});

    assign w_sigma     = {{14{r_c1s[36]}}, r_c1s} + {r_dp[49], r_dp};
    assign w_sigma_abs = w_sigma[50] ? -w_sigma : w_sigma;

    always_comb begin
        w_step = '0;
        if (r_sgn == SGN_POS) begin
            w_step = $signed({14'd0, i_cfg.integrator_step});
        end else if (r_sgn == SGN_NEG) begin
            w_step = -$signed({14'd0, i_cfg.integrator_step});
        end
    end
    assign w_isum = {{2{r_int[STATE_W-1]}}, r_int} + w_step;

    // one root bit per step
    assign w_rem_t = {r_rem, r_rad[MAG_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_rem_d = w_rem_t - w_trial;

    assign w_rgp = r_root * i_cfg.root_gain;

    always_comb begin
        w_rts = $signed({2'b00, r_rt});
        if (r_sgn == SGN_NEG) begin
            w_rts = -$signed({2'b00, r_rt});
        end else if (r_sgn == SGN_ZERO) begin
            w_rts = '0;
        end
    end
    assign w_u = w_rts + {{9{r_int[STATE_W-1]}}, r_int};

    assign w_dlo = r_um[23:0] * i_cfg.degree_scale;
    assign w_om  = {1'b0, r_dhi} + {18'd0, r_dlo};

    always_comb begin
        w_clip  = 1'b0;
        w_angle = r_uneg ? -w_om[ANGLE_W-1:0] : w_om[ANGLE_W-1:0];
        if (!r_uneg && (w_om > 42'd8388607)) begin
            w_clip  = 1'b1;
            w_angle = 24'h7FFFFF;
        end else if (r_uneg && (w_om > 42'd8388608)) begin
            w_clip  = 1'b1;
            w_angle = 24'h800000;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px <= i_pixel_error;
        end
        if (i_cmd.scale) begin
            if (w_neg[37:31] != {7{w_neg[37]}}) begin
                r_e <= w_neg[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r_e <= w_neg[31:0];
            end
        end
        if (i_cmd.c1_mul) begin
            r_c1s <= w_c1p[52:16];
        end
        if (i_cmd.diff_mul) begin
            r_dp <= w_dpm;
        end
        if (i_cmd.sigma) begin
            r_mag <= w_sigma_abs[MAG_W-1:0];
            if (w_sigma[50]) begin
                r_sgn <= SGN_NEG;
            end else if (w_sigma != '0) begin
                r_sgn <= SGN_POS;
            end else begin
                r_sgn <= SGN_ZERO;
            end
        end
        if (i_cmd.integ) begin
            r_sat_i <= (w_isum[33:31] != {3{w_isum[33]}});
            r_rad   <= r_mag;
            r_rem   <= '0;
            r_root  <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad <= {r_rad[MAG_W-3:0], 2'b00};
            if (w_rem_t >= w_trial) begin
                r_rem  <= w_rem_d[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_t[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.gain_mul) begin
            r_rt <= w_rgp[44:6];
        end
        if (i_cmd.u_form) begin
            r_uneg <= w_u[40];
            r_um   <= w_u[40] ? 41'(-w_u) : 41'(w_u);
        end
        if (i_cmd.deg_hi) begin
            r_dhi <= r_um[40:24] * i_cfg.degree_scale;
        end
        if (i_cmd.deg_lo) begin
            r_dlo <= w_dlo[47:24];
        end
        if (i_cmd.emit) begin
            r_angle <= w_angle;
            r_osgn  <= r_sgn;
            r_osat  <= r_sat_i | w_clip;
        end
    end

    // previous error, integrator and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_int    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.integ) begin
                r_prev <= r_e;
                if (w_isum[33:31] != {3{w_isum[33]}}) begin
                    r_int <= w_isum[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_int <= w_isum[31:0];
                end
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy = r_ovalid & ~i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_angle        = r_angle;
    assign o_surface_sign = r_osgn;
    assign o_saturated    = r_osat;

endmodule

### src/super_twisting_steering_control_top.sv
// ----------------------------------------------------------------------------
// super_twisting_steering_control_top
// super-twisting sliding-mode steering controller: pixel error in,
// saturated steering angle in degrees out
// ----------------------------------------------------------------------------
//  port group   | dir | contents
//  i_s_axis_*   | in  | tdata[11:0] pixel_error
//  o_m_axis_*   | out | tdata[23:0] angle, [25:24] surface_sign; tuser saturated
//  i_cfg_*      | in  | register write: index, 24 bit data
//
//  the 25 steps of the bit-serial square root make up most of the sequence
//  from acceptance to a valid result
//  a new item is accepted once the previous one has left the datapath
//  a finished item waits in the last step while the output register is
//  still held by a stalled sink
//  reset restores register defaults and clears previous error and integrator
// ----------------------------------------------------------------------------
module super_twisting_steering_control_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [15:0]                         i_s_axis_tdata,   // pixel_error
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [31:0]                         o_m_axis_tdata,   // angle, surface_sign
    output logic                                o_m_axis_tuser,   // saturated
    input  logic                                i_cfg_we,
    input  logic [stsc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [stsc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import stsc_pkg::*;

    t_cfg               w_cfg;
    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [ANGLE_W-1:0] w_angle;
    logic [SIGN_W-1:0]  w_sgn;

    stsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    stsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    stsc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg          (w_cfg),
        .i_pixel_error  ($signed(i_s_axis_tdata[PIXEL_W-1:0])),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_angle        (w_angle),
        .o_surface_sign (w_sgn),
        .o_saturated    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {6'd0, w_sgn, w_angle};

endmodule
